>>> rtl/rcc_pkg.sv
// ---------------------------------------------------------------------------
// rcc_pkg
// shared constants and codes for the residue class coverage counter
// ---------------------------------------------------------------------------
package rcc_pkg;

  // default sizing of the counter store
  localparam int DEF_MAX_RESIDUES = 65536;
  localparam int DEF_COUNT_WIDTH  = 16;

  // width and saturation limit of the 17-bit count fields
  localparam int FIELD_W   = 17;
  localparam int FIELD_MAX = 131071;

  // ring size after reset
  localparam int RING_RESET = 65536;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_MARK   = 2'd0;
  localparam kind_t KIND_UNMARK = 2'd1;
  localparam kind_t KIND_GAIN   = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

endpackage

>>> rtl/rcc_ram.sv
// ---------------------------------------------------------------------------
// rcc_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module rcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/residue_class_coverage_counter.sv
// a new result waits for out_ready while an earlier result is still held
// one transaction at a time, the next one taken once the result is loaded
// clear transaction and reset: zeroing sweep over all MAX_RESIDUES entries
//   (65536 by default), one ram entry per cycle, in_ready low meanwhile
// reset: synchronous active low, ring size back to 65536, sweep starts at once
// ---------------------------------------------------------------------------
// residue_class_coverage_counter
// per-residue cover counters in ram with a running uncovered count
// ---------------------------------------------------------------------------
module residue_class_coverage_counter #(
  parameter int MAX_RESIDUES = rcc_pkg::DEF_MAX_RESIDUES,
  parameter int COUNT_WIDTH  = rcc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input transactions
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_kind,
  input  logic [15:0]                in_start_residue,
  input  logic [rcc_pkg::FIELD_W-1:0] in_stride,
  // result transactions
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rcc_pkg::FIELD_W-1:0] out_changed_count,
  output logic [rcc_pkg::FIELD_W-1:0] out_uncovered_total,
  output logic                       out_fault,
  // ring size register
  input  logic                       cfg_wr_en,
  input  logic [rcc_pkg::FIELD_W-1:0] cfg_wr_data
);

  import rcc_pkg::*;

  // address, effective length and residue walk widths
  localparam int AW = $clog2(MAX_RESIDUES);
  localparam int LW = $clog2(MAX_RESIDUES + 1);
  localparam int EW = (LW > FIELD_W) ? LW : FIELD_W;
  localparam int RW = EW + 1;

  localparam int RESET_LEN = (RING_RESET > MAX_RESIDUES) ? MAX_RESIDUES : RING_RESET;
  localparam logic [FIELD_W-1:0] RESET_UNC =
    FIELD_W'((RESET_LEN > FIELD_MAX) ? FIELD_MAX : RESET_LEN);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_RESIDUES - 1);
  localparam logic [EW-1:0] MAX_EXT   = EW'(MAX_RESIDUES);
  localparam logic [EW-1:0] SAT_EXT   = EW'(FIELD_MAX);
  localparam logic [FIELD_W-1:0] SAT_FIELD = FIELD_W'(FIELD_MAX);

  // controller states
  localparam logic [1:0] ST_INIT = 2'd0;  // zeroing sweep
  localparam logic [1:0] ST_IDLE = 2'd1;  // waiting for a transaction
  localparam logic [1:0] ST_RUN  = 2'd2;  // walking the residue class
  localparam logic [1:0] ST_DONE = 2'd3;  // handing over the result

  logic [1:0]             state_r;
  logic [AW-1:0]          clr_addr_r;
  logic                   clr_op_r;
  logic [FIELD_W-1:0]     ring_r;
  logic [FIELD_W-1:0]     unc_r;
  kind_t                  kind_r;
  logic [FIELD_W-1:0]     stride_r;
  logic [RW-1:0]          res_r;
  logic                   stop_r;
  logic                   pend_r;
  logic [AW-1:0]          pend_addr_r;
  logic [FIELD_W-1:0]     chg_r;
  logic                   fault_r;
  logic                   out_valid_r;
  logic [FIELD_W-1:0]     out_chg_r;
  logic [FIELD_W-1:0]     out_unc_r;
  logic                   out_fault_r;

  logic [FIELD_W-1:0]     chg_nxt;
  logic [FIELD_W-1:0]     unc_nxt;
  logic                   fault_nxt;

  logic [EW-1:0]          ring_ext;
  logic [EW-1:0]          len_ext;
  logic [FIELD_W-1:0]     len_sat;
  logic                   issue;
  logic [AW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  // effective ring length, limited to the store depth
  assign ring_ext = EW'(ring_r);
  assign len_ext  = (ring_ext > MAX_EXT) ? MAX_EXT : ring_ext;
  assign len_sat  = (len_ext > SAT_EXT) ? SAT_FIELD : len_ext[FIELD_W-1:0];

  // next residue is read while the previous one is written back; residues of
  // one class are distinct, so the two ports never meet on the same entry
  assign issue   = (state_r == ST_RUN) && !stop_r && (res_r < {1'b0, len_ext});
  assign rd_addr = res_r[AW-1:0];

  rcc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_RESIDUES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // modify stage: counter update and running counts
  always_comb begin
    we        = 1'b0;
    waddr     = pend_addr_r;
    wdata     = rd_data;
    chg_nxt   = chg_r;
    unc_nxt   = unc_r;
    fault_nxt = fault_r;
    if (state_r == ST_INIT) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else if (pend_r) begin
      unique case (kind_r)
        KIND_MARK: begin
          if (&rd_data) begin
            // counter full, saturate
            fault_nxt = 1'b1;
          end else begin
            we    = 1'b1;
            wdata = rd_data + 1'b1;
            if (rd_data == '0) begin
              chg_nxt = (chg_r == SAT_FIELD) ? chg_r : chg_r + 1'b1;
              unc_nxt = (unc_r == '0) ? unc_r : unc_r - 1'b1;
            end
          end
        end
        KIND_UNMARK: begin
          if (rd_data == '0) begin
            // counter empty, stays at zero
            fault_nxt = 1'b1;
          end else begin
            we    = 1'b1;
            wdata = rd_data - 1'b1;
            if (rd_data == COUNT_WIDTH'(1)) begin
              chg_nxt = (chg_r == SAT_FIELD) ? chg_r : chg_r + 1'b1;
              unc_nxt = (unc_r == SAT_FIELD) ? unc_r : unc_r + 1'b1;
            end
          end
        end
        KIND_GAIN: begin
          if (rd_data == '0) begin
            chg_nxt = (chg_r == SAT_FIELD) ? chg_r : chg_r + 1'b1;
          end
        end
        KIND_CLEAR: begin
          // handled by the zeroing sweep
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_addr_r  <= '0;
      clr_op_r    <= 1'b0;
      ring_r      <= FIELD_W'(RING_RESET);
      unc_r       <= RESET_UNC;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ring_r <= cfg_wr_data;
      end
      // result taken; a new one loaded in the done state keeps valid high
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          if (clr_addr_r == LAST_ADDR) begin
            clr_addr_r <= '0;
            state_r    <= clr_op_r ? ST_DONE : ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            kind_r   <= in_kind;
            stride_r <= in_stride;
            res_r    <= RW'(in_start_residue);
            stop_r   <= 1'b0;
            pend_r   <= 1'b0;
            chg_r    <= '0;
            fault_r  <= 1'b0;
            if (in_kind == KIND_CLEAR) begin
              clr_op_r <= 1'b1;
              unc_r    <= len_sat;
              state_r  <= ST_INIT;
            end else begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          pend_r      <= issue;
          pend_addr_r <= rd_addr;
          chg_r       <= chg_nxt;
          unc_r       <= unc_nxt;
          fault_r     <= fault_nxt;
          if (issue) begin
            res_r <= res_r + RW'(stride_r);
            // zero stride visits the start residue once
            if (stride_r == '0) begin
              stop_r <= 1'b1;
            end
          end
          if (!issue && !pend_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_chg_r   <= chg_r;
            out_unc_r   <= unc_r;
            out_fault_r <= fault_r;
            clr_op_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_changed_count   = out_chg_r;
  assign out_uncovered_total = out_unc_r;
  assign out_fault           = out_fault_r;

endmodule

>>> rtl/rcc_checker.sv
// ---------------------------------------------------------------------------
// rcc_checker
// port-level checks of the residue class coverage counter
// ---------------------------------------------------------------------------
module rcc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rcc_pkg::FIELD_W-1:0] out_changed_count,
  input logic [rcc_pkg::FIELD_W-1:0] out_uncovered_total,
  input logic                        out_fault
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_changed_count)
      && $stable(out_uncovered_total) && $stable(out_fault))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset starts the zeroing sweep with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("reset did not clear control");

  // a fresh result frees the input side in the same cycle
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while still busy");

endmodule

bind residue_class_coverage_counter rcc_checker u_rcc_checker (.*);

>>> tb/tb_residue_class_coverage_counter.sv
// ---------------------------------------------------------------------------
// tb_residue_class_coverage_counter
// drives mark, unmark, gain and clear transactions into the coverage counter,
// predicts every result with an in-bench copy of the counter store and checks
// each returned result field by field, under random idling on both channels
// ---------------------------------------------------------------------------
module tb_residue_class_coverage_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  // one input transaction and one result transaction
  typedef struct packed {
    kind_t              kind;
    logic [15:0]        start;
    logic [FIELD_W-1:0] stride;
  } cover_op_t;

  typedef struct packed {
    logic [FIELD_W-1:0] changed;
    logic [FIELD_W-1:0] uncovered;
    logic               fault;
  } cover_res_t;

  localparam int IDLE_PCT       = 12;
  localparam int HOLD_CYCLES    = 500;
  // slowest legal gap is a full-ring walk or a zeroing sweep
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int PHASE_ITEMS    = 94;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = KIND_MARK;
  logic [15:0]        in_start_residue = '0;
  logic [FIELD_W-1:0] in_stride = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_changed_count;
  logic [FIELD_W-1:0] out_uncovered_total;
  logic               out_fault;

  logic               cfg_wr_en = 1'b0;
  logic [FIELD_W-1:0] cfg_wr_data = '0;

  // predictor state: counter store, uncovered count and ring size register
  logic [DEF_COUNT_WIDTH-1:0] cover_cnt [DEF_MAX_RESIDUES];
  int unsigned                uncovered_now;
  logic [FIELD_W-1:0]         ring_setting;

  cover_op_t  pending_ops [$];
  cover_res_t predicted_results [$];
  cover_op_t  offered_op;

  // stimulus control shared with the driver and the receiver
  logic steady    = 1'b0;
  logic hold_arm  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int unsigned kind_seen [4];
  int unsigned results_checked = 0;
  int unsigned faults_seen     = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;

  residue_class_coverage_counter u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_start_residue    (in_start_residue),
    .in_stride           (in_stride),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_changed_count   (out_changed_count),
    .out_uncovered_total (out_uncovered_total),
    .out_fault           (out_fault),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: walks start, start+stride, ... below the effective ring size and
  // updates the in-bench store exactly as the block should
  // ---------------------------------------------------------------------------
  function automatic cover_res_t apply_cover_op(input cover_op_t op);
    int unsigned span;
    int unsigned r;
    int unsigned hits;
    logic        walking;
    cover_res_t  res;
    // ring sizes above the store depth are clipped to the store depth
    span = 32'(ring_setting);
    if (span > DEF_MAX_RESIDUES) span = DEF_MAX_RESIDUES;
    hits = 0;
    res.fault = 1'b0;
    if (op.kind == KIND_CLEAR) begin
      foreach (cover_cnt[i]) cover_cnt[i] = '0;
      uncovered_now = span;
    end else begin
      r = 32'(op.start);
      walking = (r < span);
      while (walking) begin
        case (op.kind)
          KIND_MARK: begin
            // full counter saturates and flags a fault
            if (cover_cnt[r] == '1) begin
              res.fault = 1'b1;
            end else begin
              if (cover_cnt[r] == '0) begin
                hits++;
                if (uncovered_now > 0) uncovered_now--;
              end
              cover_cnt[r] = cover_cnt[r] + 1'b1;
            end
          end
          KIND_UNMARK: begin
            // zero counter stays at zero, count untouched, fault flagged
            if (cover_cnt[r] == '0) begin
              res.fault = 1'b1;
            end else begin
              if (cover_cnt[r] == 1) begin
                hits++;
                if (uncovered_now < FIELD_MAX) uncovered_now++;
              end
              cover_cnt[r] = cover_cnt[r] - 1'b1;
            end
          end
          default: begin
            if (cover_cnt[r] == '0) hits++;
          end
        endcase
        // zero stride visits the start residue only
        if (op.stride == 0) begin
          walking = 1'b0;
        end else begin
          r = r + 32'(op.stride);
          walking = (r < span);
        end
      end
    end
    res.changed   = FIELD_W'((hits > FIELD_MAX) ? FIELD_MAX : hits);
    res.uncovered = FIELD_W'(uncovered_now);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued transactions, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // accepted at this edge: predict against the current store
      if (in_valid && in_ready) begin
        predicted_results.push_back(apply_cover_op(offered_op));
        kind_seen[offered_op.kind]++;
      end
      // slot is free: offer the next transaction or leave valid low
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          offered_op = pending_ops.pop_front();
          in_valid         <= 1'b1;
          in_kind          <= offered_op.kind;
          in_start_residue <= offered_op.start;
          in_stride        <= offered_op.stride;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each result against the oldest prediction, stalls at
  // random and once holds off for a long stretch so the block backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cover_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (out_fault === 1'b1) faults_seen++;
        if (predicted_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_changed_count !== want.changed) begin
            $error("changed_count: expected %0d, got %0d", want.changed, out_changed_count);
            mismatches++;
          end
          if (out_uncovered_total !== want.uncovered) begin
            $error("uncovered_total: expected %0d, got %0d",
                   want.uncovered, out_uncovered_total);
            mismatches++;
          end
          if (out_fault !== want.fault) begin
            $error("fault: expected %0b, got %0b", want.fault, out_fault);
            mismatches++;
          end
        end
      end
      // long hold-off, armed once by the stimulus
      if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long without any accepted transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_op(input kind_t kind, input int unsigned start,
                          input int unsigned stride);
    cover_op_t op;
    op.kind   = kind;
    op.start  = 16'(start);
    op.stride = FIELD_W'(stride);
    pending_ops.push_back(op);
  endtask

  // block idle: nothing queued or in flight, every result back, input ready
  // sampled at the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || predicted_results.size() != 0 ||
           !in_ready) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ring(input int unsigned value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= FIELD_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ring_setting = FIELD_W'(value);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ring_plan [8];
    cover_op_t   residue_pool [$];
    cover_op_t   op;
    int unsigned span;
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    int unsigned clear_at;

    foreach (cover_cnt[i]) cover_cnt[i] = '0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    ring_setting  = RING_RESET;
    uncovered_now = RING_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // reset starts a zeroing sweep, input ready stays low until it is done
    wait_idle();

    // directed part on the reset ring size
    queue_op(KIND_MARK,   0,     1);        // every residue covered at once
    queue_op(KIND_GAIN,   0,     4096);     // nothing left to gain
    queue_op(KIND_UNMARK, 65535, 65536);    // top residue uncovered again
    queue_op(KIND_UNMARK, 65535, 65536);    // already zero: fault
    queue_op(KIND_GAIN,   65535, 131071);   // widest stride field
    queue_op(KIND_MARK,   65535, 0);        // zero stride, one visit
    queue_op(KIND_MARK,   100,   0);        // counter goes to two
    queue_op(KIND_UNMARK, 100,   0);
    queue_op(KIND_UNMARK, 100,   0);
    wait_idle();

    // empty ring: nothing visited, clear leaves no uncovered residues
    write_ring(0);
    queue_op(KIND_MARK,  0, 1);
    queue_op(KIND_CLEAR, 0, 1);
    wait_idle();

    // ring above the store depth, uncovered count starting at zero
    write_ring(FIELD_MAX);
    queue_op(KIND_GAIN,   0, 8192);
    queue_op(KIND_MARK,   0, 8192);         // count cannot go below zero
    queue_op(KIND_UNMARK, 0, 16384);
    queue_op(KIND_UNMARK, 4, 16384);        // untouched residues: fault
    wait_idle();

    write_ring(300);
    queue_op(KIND_MARK, 299, 1);            // last residue of the ring
    queue_op(KIND_MARK, 300, 1);            // start at the ring size
    queue_op(KIND_GAIN, 0,   65536);
    wait_idle();

    write_ring(1);
    queue_op(KIND_MARK,   65535, 1);        // start far beyond the ring
    queue_op(KIND_UNMARK, 0,     131071);
    wait_idle();

    // random part: several ring sizes, mostly reused residue classes so that
    // counters climb and fall again, the rest fresh or out-of-range classes
    ring_plan = '{2, 7, 1, 64, 300, 4096, 65536, 0};
    ring_plan[7] = $urandom_range(1, 65536);
    for (int ph = 0; ph < 8; ph++) begin
      write_ring(ring_plan[ph]);
      span = (ring_plan[ph] > DEF_MAX_RESIDUES) ? DEF_MAX_RESIDUES : ring_plan[ph];
      steady   = (ph == 1);                 // no idling on either side here
      hold_arm = (ph >= 3);                 // long receiver hold-off from here on
      clear_at = (ph == 0) ? 0 : (ph == 5) ? $urandom_range(1, PHASE_ITEMS - 1) :
                 PHASE_ITEMS;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == clear_at) begin
          queue_op(KIND_CLEAR, $urandom & 16'hFFFF, $urandom & FIELD_MAX);
        end else if (residue_pool.size() != 0 && $urandom_range(0, 99) < 55) begin
          op = residue_pool[$urandom_range(0, residue_pool.size() - 1)];
          sel = $urandom_range(0, 99);
          op.kind = (sel < 40) ? KIND_MARK : (sel < 75) ? KIND_UNMARK : KIND_GAIN;
          pending_ops.push_back(op);
        end else begin
          sel = $urandom_range(0, 99);
          op.kind = (sel < 40) ? KIND_MARK : (sel < 72) ? KIND_UNMARK : KIND_GAIN;
          if ($urandom_range(0, 99) < 80) op.start = 16'($urandom_range(0, span - 1));
          else op.start = 16'($urandom);
          sel = $urandom_range(0, 99);
          if (sel < 8) begin
            op.stride = 0;
          end else if (sel < 20) begin
            op.stride = FIELD_W'($urandom);
            // keep long walks out of the large rings
            if (span > 1024 && op.stride != 0 && op.stride < span / 64)
              op.stride = op.stride | 17'h10000;
          end else begin
            lo = (span > 1024) ? span / 64 : 1;
            hi = span;
            op.stride = FIELD_W'($urandom_range(lo, hi));
          end
          pending_ops.push_back(op);
          residue_pool.push_back(op);
          if (residue_pool.size() > 6) void'(residue_pool.pop_front());
        end
      end
      wait_idle();
    end
    steady = 1'b0;

    // nothing in flight any more: allow the block's own latency to pass
    repeat (16) @(posedge clk);

    $display("checked %0d results from %0d mark, %0d unmark, %0d gain, %0d clear transactions",
             results_checked, kind_seen[KIND_MARK], kind_seen[KIND_UNMARK],
             kind_seen[KIND_GAIN], kind_seen[KIND_CLEAR]);
    $display("%0d results carried a fault; rings from empty to oversized, long result stall",
             faults_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
